### sv/ambient_light_pwm_dimmer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ambient light PWM dimmer.
// ----------------------------------------------------------------------------
`ifndef AMBIENT_LIGHT_PWM_DIMMER_CORE_ASSERT_SVH
`define AMBIENT_LIGHT_PWM_DIMMER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/alpd_pkg.sv
// ----------------------------------------------------------------------------
// alpd_pkg
// Types and constants of the ambient light PWM dimmer.
// ----------------------------------------------------------------------------
`default_nettype none

package alpd_pkg;

  localparam int FILTER_SHIFT = 8;
  localparam int SAMPLE_BITS  = 12;
  localparam int PERIOD       = 1024;

  localparam int LEVEL_BITS = 10;
  localparam int SHIFT_BITS = 4;
  localparam int CMP_BITS   = 11;
  localparam int CFG_IDX_BITS = 2;

  // Reciprocal 2^RECIP_EXP / f, done one quotient bit per cycle.
  localparam int RECIP_EXP  = 24;
  localparam int QUOT_BITS  = RECIP_EXP + 1;
  localparam int EST_BITS   = QUOT_BITS + 1;
  localparam int EST_OFFSET = 4096;
  localparam int CNT_BITS   = $clog2(QUOT_BITS);

  localparam int SUM_BITS   = SAMPLE_BITS + FILTER_SHIFT;

  localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = CMP_BITS + SAMPLE_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [LEVEL_BITS-1:0] MIN_LEVEL_RST = LEVEL_BITS'(40);
  localparam logic [LEVEL_BITS-1:0] MAX_LEVEL_RST = LEVEL_BITS'(1023);
  localparam logic [SHIFT_BITS-1:0] SENS_SHIFT_RST = SHIFT_BITS'(6);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_LEVEL  = 2'd0,
    REG_MAX_LEVEL  = 2'd1,
    REG_SENS_SHIFT = 2'd2
  } alpd_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCALE,
    ST_EMIT
  } alpd_state_e;

endpackage

`default_nettype wire

### sv/ambient_light_pwm_dimmer_core.sv
// ----------------------------------------------------------------------------
// ambient_light_pwm_dimmer_core
// Smooths light samples and turns them into an inverted PWM compare value.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel, one 12-bit reading per request.
//   Each sample updates an exponential moving average, whose value f gives
//   the light estimate 2^24 / f - 4096, shifted and clamped to the level
//   range. One result per sample leaves on m_axis.
//   Registers are written on the cfg channel (always ready); the user must
//   write them only while idle, which the block itself does not enforce.
//   The restoring divider shares one subtractor and forms one quotient bit
//   per cycle, followed by a scale step and a clamp step into the output
//   register; a new sample is accepted only after that register is loaded.
//   The result sits in an output register, so a stalled receiver does not
//   stop the next sample; the block waits only if a new result is ready
//   while the previous one has not been taken.
//   Reset clears the filter state and loads the register defaults
//   (min 40, max 1023, shift 6).
// ----------------------------------------------------------------------------
`default_nettype none

module ambient_light_pwm_dimmer_core
  import alpd_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // tdata: [11:0] light_sample
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i,
  // tdata: [10:0] compare_value, [22:11] smoothed_level
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [LEVEL_BITS-1:0]     cfg_data_i
);

  alpd_state_e state_q, state_d;

  logic [LEVEL_BITS-1:0]   min_q;
  logic [LEVEL_BITS-1:0]   max_q;
  logic [SHIFT_BITS-1:0]   sens_q;

  logic [SAMPLE_BITS-1:0]  avg_q, avg_d;
  logic [FILTER_SHIFT-1:0] rem_q, rem_d;
  logic [SAMPLE_BITS:0]    div_rem_q, div_rem_d;
  logic [QUOT_BITS-1:0]    quot_q, quot_d;
  logic [CNT_BITS-1:0]     cnt_q, cnt_d;
  logic signed [EST_BITS-1:0] level_q, level_d;

  logic                    out_valid_q, out_valid_d;
  logic [CMP_BITS-1:0]     out_cmp_q, out_cmp_d;
  logic [SAMPLE_BITS-1:0]  out_smooth_q, out_smooth_d;

  logic                    in_accept;
  logic                    emit_load;
  logic                    div_last;
  logic [SUM_BITS-1:0]     filt_sum;
  logic [SAMPLE_BITS:0]    trial;
  logic [SAMPLE_BITS+1:0]  diff;
  logic                    fits;
  logic signed [EST_BITS-1:0] est;
  logic signed [EST_BITS-1:0] max_ext;
  logic signed [EST_BITS-1:0] min_ext;
  logic signed [EST_BITS-1:0] clamp_hi;
  logic signed [EST_BITS-1:0] clamp_lo;
  logic [CMP_BITS-1:0]     period_cmp;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_last) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    emit_load       = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready_i);
  end

  assign in_accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;
  assign div_last    = (cnt_q == '0);

  // ----------------------------------------------------------------- filter
  // avg * (2^FILTER_SHIFT - 1) is formed as a shift minus the value itself.
  assign filt_sum = SUM_BITS'({avg_q, {FILTER_SHIFT{1'b0}}}) - SUM_BITS'(avg_q)
                  + SUM_BITS'(s_axis_tdata_i[SAMPLE_BITS-1:0]) + SUM_BITS'(rem_q);

  // ---------------------------------------------------------------- divider
  // The dividend 2^RECIP_EXP has a single one, brought in on the first step.
  assign trial = {div_rem_q[SAMPLE_BITS-1:0], (cnt_q == CNT_BITS'(RECIP_EXP))};
  assign diff  = {1'b0, trial} - (SAMPLE_BITS+2)'(avg_q);
  assign fits  = !diff[SAMPLE_BITS+1];

  // ------------------------------------------------------------ scale/clamp
  assign est        = $signed({1'b0, quot_q}) - EST_BITS'(EST_OFFSET);
  assign max_ext    = $signed({{(EST_BITS-LEVEL_BITS){1'b0}}, max_q});
  assign min_ext    = $signed({{(EST_BITS-LEVEL_BITS){1'b0}}, min_q});
  assign clamp_hi   = (level_q > max_ext) ? max_ext : level_q;
  assign clamp_lo   = (clamp_hi < min_ext) ? min_ext : clamp_hi;
  assign period_cmp = CMP_BITS'(PERIOD);

  always_comb begin
    avg_d        = avg_q;
    rem_d        = rem_q;
    div_rem_d    = div_rem_q;
    quot_d       = quot_q;
    cnt_d        = cnt_q;
    level_d      = level_q;
    out_cmp_d    = out_cmp_q;
    out_smooth_d = out_smooth_q;
    out_valid_d  = out_valid_q;

    if (in_accept) begin
      avg_d     = filt_sum[SUM_BITS-1:FILTER_SHIFT];
      rem_d     = filt_sum[FILTER_SHIFT-1:0];
      div_rem_d = '0;
      quot_d    = '0;
      cnt_d     = CNT_BITS'(QUOT_BITS - 1);
    end

    if (state_q == ST_DIVIDE) begin
      div_rem_d = fits ? diff[SAMPLE_BITS:0] : trial;
      quot_d    = {quot_q[QUOT_BITS-2:0], fits};
      if (!div_last) begin
        cnt_d = cnt_q - CNT_BITS'(1);
      end
    end

    // A zero level has no reciprocal; the estimate saturates high.
    if (state_q == ST_SCALE) begin
      level_d = (avg_q == '0) ? max_ext : (est >>> sens_q);
    end

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit_load) begin
      out_valid_d  = 1'b1;
      out_cmp_d    = period_cmp - {1'b0, clamp_lo[LEVEL_BITS-1:0]};
      out_smooth_d = avg_q;
    end
  end

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      avg_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      avg_q       <= avg_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= MIN_LEVEL_RST;
      max_q  <= MAX_LEVEL_RST;
      sens_q <= SENS_SHIFT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MIN_LEVEL:  min_q  <= cfg_data_i;
        REG_MAX_LEVEL:  max_q  <= cfg_data_i;
        REG_SENS_SHIFT: sens_q <= cfg_data_i[SHIFT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q    <= div_rem_d;
    quot_q       <= quot_d;
    level_q      <= level_d;
    out_cmp_q    <= out_cmp_d;
    out_smooth_q <= out_smooth_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_BITS'({out_smooth_q, out_cmp_q});

  // ------------------------------------------------------------- assertions
  `include "ambient_light_pwm_dimmer_core_assert.svh"

  `ALPD_ASSERT_NEXT(a_accept_starts_div, in_accept,
    (state_q == ST_DIVIDE) && (cnt_q == CNT_BITS'(QUOT_BITS - 1)),
    "accepted request did not start the divider")

  `ALPD_ASSERT_NEXT(a_div_ends_in_scale, (state_q == ST_DIVIDE) && div_last,
    state_q == ST_SCALE, "divider did not hand over to scaling")

  `ALPD_ASSERT_SAME(a_div_rem_below_f, (state_q == ST_DIVIDE) && (avg_q != '0),
    div_rem_q < {1'b0, avg_q}, "divider remainder not below the divisor")

  `ALPD_ASSERT_SAME(a_result_from_emit, $rose(m_axis_tvalid_o),
    $past(state_q) == ST_EMIT, "result appeared outside the emit step")

endmodule

`default_nettype wire
